[rtl/rvr_pkg.sv]
// Shared constants, codes and stage payload types of the raster value reclassifier.
package rvr_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned MODE_W      = 4;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned RULE_W      = 2;
  localparam int unsigned SPECIAL_W   = 2;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [MODE_W-1:0]             mode_t;
  typedef logic [OP_W-1:0]               op_t;
  typedef logic [RULE_W-1:0]             rule_t;
  typedef logic [INDEX_W-1:0]            index_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [SPECIAL_W-1:0]          special_t;
  typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;

  localparam op_t OP_CLASSIFY = 2'd0;
  localparam op_t OP_WRITE    = 2'd1;
  localparam op_t OP_CLEAR    = 2'd2;

  localparam mode_t MODE_SINGLE_EQ     = 4'd0;
  localparam mode_t MODE_SINGLE_LT     = 4'd1;
  localparam mode_t MODE_SINGLE_LE     = 4'd2;
  localparam mode_t MODE_SINGLE_GE     = 4'd3;
  localparam mode_t MODE_SINGLE_GT     = 4'd4;
  localparam mode_t MODE_RANGE_INCL    = 4'd5;
  localparam mode_t MODE_RANGE_EXCL    = 4'd6;
  localparam mode_t MODE_TABLE_GE_LT   = 4'd7;
  localparam mode_t MODE_TABLE_GE_LE   = 4'd8;
  localparam mode_t MODE_TABLE_GT_LE   = 4'd9;
  localparam mode_t MODE_TABLE_GT_LT   = 4'd10;

  localparam rule_t RULE_PASS   = 2'd0;
  localparam rule_t RULE_MATCH  = 2'd1;
  localparam rule_t RULE_NODATA = 2'd2;
  localparam rule_t RULE_OTHER  = 2'd3;

  localparam cfg_index_t CFG_MODE           = 3'd0;
  localparam cfg_index_t CFG_THRESHOLD_LOW  = 3'd1;
  localparam cfg_index_t CFG_THRESHOLD_HIGH = 3'd2;
  localparam cfg_index_t CFG_NEW_VALUE      = 3'd3;
  localparam cfg_index_t CFG_NODATA_IN      = 3'd4;
  localparam cfg_index_t CFG_SPECIAL_ENABLE = 3'd5;
  localparam cfg_index_t CFG_NODATA_NEW     = 3'd6;
  localparam cfg_index_t CFG_OTHER_NEW      = 3'd7;

  localparam int unsigned SPECIAL_NODATA_BIT = 0;
  localparam int unsigned SPECIAL_OTHER_BIT  = 1;

  localparam value_t THRESHOLD_HIGH_RESET = value_t'(10);
  localparam value_t NEW_VALUE_RESET      = value_t'(1);
  localparam value_t NODATA_IN_RESET      = value_t'(-99999);

  typedef struct packed {
    value_t                 pixel;
    logic [TABLE_DEPTH-1:0] hit;
    logic                   nd_eq;
    logic                   meth_hit;
    logic                   table_mode;
    logic                   empty;
  } match_t;

  typedef struct packed {
    value_t pixel;
    logic   found;
    value_t code;
    logic   nd_eq;
    logic   meth_hit;
    logic   table_mode;
    logic   empty;
  } pick_t;

  typedef struct packed {
    value_t   new_value;
    value_t   nodata_new;
    value_t   other_new;
    special_t special;
  } repl_cfg_t;

endpackage

[rtl/raster_value_reclassifier_top.sv]
// Top level of the raster value reclassifier: configuration, input stage and pipeline.
// Each accepted word passes four register stages (input, compare, select, output); the
// input register is loaded at the accepting edge, and the block takes one word every
// cycle; it stalls only while the output word waits to be taken. All sixteen table
// entries are compared in parallel in the compare stage, and table writes and clears
// take effect in word order, so a classify word always sees the table as left by the
// words accepted before it. Write, clear and unused operation words give no result.
// Configuration may only be written while the pipeline is empty.
module raster_value_reclassifier_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  rvr_pkg::cfg_index_t    cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rvr_pkg::op_t           operation_i,
  input  rvr_pkg::value_t        cell_value_i,
  input  rvr_pkg::index_t        entry_index_i,
  input  rvr_pkg::value_t        entry_min_i,
  input  rvr_pkg::value_t        entry_max_i,
  input  rvr_pkg::value_t        entry_code_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rvr_pkg::value_t        result_value_o,
  output rvr_pkg::rule_t         rule_used_o,
  output logic                   table_empty_o
);
  import rvr_pkg::*;

  mode_t     mode_q;
  value_t    threshold_low_q;
  value_t    threshold_high_q;
  value_t    new_value_q;
  value_t    nodata_in_q;
  special_t  special_q;
  value_t    nodata_new_q;
  value_t    other_new_q;

  logic      adv;
  logic      v1_q;
  op_t       op1_q;
  value_t    cell1_q;
  index_t    idx1_q;
  value_t    min1_q;
  value_t    max1_q;
  value_t    code1_q;

  logic      tbl_we;
  logic      tbl_clr;
  value_t    tbl_low  [TABLE_DEPTH];
  value_t    tbl_high [TABLE_DEPTH];
  value_t    tbl_code [TABLE_DEPTH];
  count_t    tbl_count;

  logic      v2;
  match_t    match2;
  logic      v3;
  pick_t     pick3;
  repl_cfg_t repl_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= MODE_SINGLE_EQ;
      threshold_low_q  <= '0;
      threshold_high_q <= THRESHOLD_HIGH_RESET;
      new_value_q      <= NEW_VALUE_RESET;
      nodata_in_q      <= NODATA_IN_RESET;
      special_q        <= '0;
      nodata_new_q     <= '0;
      other_new_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:           mode_q           <= cfg_data_i[MODE_W-1:0];
        CFG_THRESHOLD_LOW:  threshold_low_q  <= cfg_data_i[VALUE_WIDTH-1:0];
        CFG_THRESHOLD_HIGH: threshold_high_q <= cfg_data_i[VALUE_WIDTH-1:0];
        CFG_NEW_VALUE:      new_value_q      <= cfg_data_i[VALUE_WIDTH-1:0];
        CFG_NODATA_IN:      nodata_in_q      <= cfg_data_i[VALUE_WIDTH-1:0];
        CFG_SPECIAL_ENABLE: special_q        <= cfg_data_i[SPECIAL_W-1:0];
        CFG_NODATA_NEW:     nodata_new_q     <= cfg_data_i[VALUE_WIDTH-1:0];
        CFG_OTHER_NEW:      other_new_q      <= cfg_data_i[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q   <= operation_i;
      cell1_q <= cell_value_i;
      idx1_q  <= entry_index_i;
      min1_q  <= entry_min_i;
      max1_q  <= entry_max_i;
      code1_q <= entry_code_i;
    end
  end

  assign tbl_we  = adv && v1_q && (op1_q == OP_WRITE);
  assign tbl_clr = adv && v1_q && (op1_q == OP_CLEAR);

  rvr_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .clr_i   (tbl_clr),
    .idx_i   (idx1_q),
    .min_i   (min1_q),
    .max_i   (max1_q),
    .code_i  (code1_q),
    .low_o   (tbl_low),
    .high_o  (tbl_high),
    .code_o  (tbl_code),
    .count_o (tbl_count)
  );

  rvr_match u_match (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .valid_i          (v1_q && (op1_q == OP_CLASSIFY)),
    .cell_i           (cell1_q),
    .mode_i           (mode_q),
    .threshold_low_i  (threshold_low_q),
    .threshold_high_i (threshold_high_q),
    .nodata_in_i      (nodata_in_q),
    .low_i            (tbl_low),
    .high_i           (tbl_high),
    .count_i          (tbl_count),
    .valid_o          (v2),
    .match_o          (match2)
  );

  rvr_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v2),
    .match_i (match2),
    .code_i  (tbl_code),
    .valid_o (v3),
    .pick_o  (pick3)
  );

  always_comb begin
    repl_cfg.new_value  = new_value_q;
    repl_cfg.nodata_new = nodata_new_q;
    repl_cfg.other_new  = other_new_q;
    repl_cfg.special    = special_q;
  end

  rvr_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (v3),
    .pick_i   (pick3),
    .cfg_i    (repl_cfg),
    .valid_o  (out_valid_o),
    .result_o (result_value_o),
    .rule_o   (rule_used_o),
    .empty_o  (table_empty_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tbl_count) <= TABLE_DEPTH)
    else $error("table entry count exceeds table depth");

  a_empty_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_empty_o |-> rule_used_o == RULE_PASS)
    else $error("empty table result was replaced");

  a_nodata_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rule_used_o == RULE_NODATA) |->
      special_q[SPECIAL_NODATA_BIT] && (result_value_o == nodata_new_q))
    else $error("no-data replacement without enable");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_clr |=> tbl_count == '0)
    else $error("table clear left entries");

endmodule

[rtl/rvr_table.sv]
// Reclassification table storage with entry writes, clear and entry count.
module rvr_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic            clr_i,
  input  rvr_pkg::index_t idx_i,
  input  rvr_pkg::value_t min_i,
  input  rvr_pkg::value_t max_i,
  input  rvr_pkg::value_t code_i,
  output rvr_pkg::value_t low_o  [rvr_pkg::TABLE_DEPTH],
  output rvr_pkg::value_t high_o [rvr_pkg::TABLE_DEPTH],
  output rvr_pkg::value_t code_o [rvr_pkg::TABLE_DEPTH],
  output rvr_pkg::count_t count_o
);
  import rvr_pkg::*;

  value_t low_q  [TABLE_DEPTH];
  value_t high_q [TABLE_DEPTH];
  value_t code_q [TABLE_DEPTH];
  count_t count_q;
  logic   in_range;

  assign in_range = 32'(idx_i) < TABLE_DEPTH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        low_q[i]  <= '0;
        high_q[i] <= '0;
        code_q[i] <= '0;
      end
    end else if (clr_i) begin
      count_q <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        low_q[i]  <= '0;
        high_q[i] <= '0;
        code_q[i] <= '0;
      end
    end else if (we_i && in_range) begin
      count_q <= COUNT_W'(32'(idx_i) + 32'd1);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (32'(idx_i) == i) begin
          low_q[i]  <= min_i;
          high_q[i] <= max_i;
          code_q[i] <= code_i;
        end
      end
    end
  end

  assign low_o   = low_q;
  assign high_o  = high_q;
  assign code_o  = code_q;
  assign count_o = count_q;

endmodule

[rtl/rvr_match.sv]
// Compare stage: threshold tests and parallel bound tests against every table entry.
module rvr_match (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  rvr_pkg::value_t cell_i,
  input  rvr_pkg::mode_t  mode_i,
  input  rvr_pkg::value_t threshold_low_i,
  input  rvr_pkg::value_t threshold_high_i,
  input  rvr_pkg::value_t nodata_in_i,
  input  rvr_pkg::value_t low_i  [rvr_pkg::TABLE_DEPTH],
  input  rvr_pkg::value_t high_i [rvr_pkg::TABLE_DEPTH],
  input  rvr_pkg::count_t count_i,
  output logic            valid_o,
  output rvr_pkg::match_t match_o
);
  import rvr_pkg::*;

  mode_t  mode_n;
  logic   lo_incl;
  logic   hi_incl;
  logic   lo_ok;
  logic   hi_ok;
  match_t match_d;
  match_t match_q;
  logic   valid_q;

  always_comb begin
    mode_n  = (mode_i > MODE_TABLE_GT_LT) ? MODE_SINGLE_EQ : mode_i;
    lo_incl = (mode_n == MODE_TABLE_GE_LT) || (mode_n == MODE_TABLE_GE_LE);
    hi_incl = (mode_n == MODE_TABLE_GE_LE) || (mode_n == MODE_TABLE_GT_LE);

    match_d            = '0;
    match_d.pixel      = cell_i;
    match_d.nd_eq      = cell_i == nodata_in_i;
    match_d.table_mode = mode_n >= MODE_TABLE_GE_LT;
    match_d.empty      = match_d.table_mode && (count_i == '0);

    unique case (mode_n)
      MODE_SINGLE_EQ:  match_d.meth_hit = cell_i == threshold_low_i;
      MODE_SINGLE_LT:  match_d.meth_hit = cell_i < threshold_low_i;
      MODE_SINGLE_LE:  match_d.meth_hit = cell_i <= threshold_low_i;
      MODE_SINGLE_GE:  match_d.meth_hit = cell_i >= threshold_low_i;
      MODE_SINGLE_GT:  match_d.meth_hit = cell_i > threshold_low_i;
      MODE_RANGE_INCL: match_d.meth_hit = (threshold_low_i <= cell_i) &&
                                          (cell_i <= threshold_high_i);
      MODE_RANGE_EXCL: match_d.meth_hit = (threshold_low_i < cell_i) &&
                                          (cell_i < threshold_high_i);
      default:         match_d.meth_hit = 1'b0;
    endcase

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lo_ok = lo_incl ? (cell_i >= low_i[i]) : (cell_i > low_i[i]);
      hi_ok = hi_incl ? (cell_i <= high_i[i]) : (cell_i < high_i[i]);
      match_d.hit[i] = lo_ok && hi_ok && (32'(count_i) > i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      match_q <= match_d;
    end
  end

  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

[rtl/rvr_select.sv]
// Select stage: picks the code of the first matching table entry.
module rvr_select (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  rvr_pkg::match_t match_i,
  input  rvr_pkg::value_t code_i [rvr_pkg::TABLE_DEPTH],
  output logic            valid_o,
  output rvr_pkg::pick_t  pick_o
);
  import rvr_pkg::*;

  pick_t pick_d;
  pick_t pick_q;
  logic  valid_q;

  always_comb begin
    pick_d            = '0;
    pick_d.pixel      = match_i.pixel;
    pick_d.found      = |match_i.hit;
    pick_d.nd_eq      = match_i.nd_eq;
    pick_d.meth_hit   = match_i.meth_hit;
    pick_d.table_mode = match_i.table_mode;
    pick_d.empty      = match_i.empty;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match_i.hit[i]) begin
        pick_d.code = code_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pick_q <= pick_d;
    end
  end

  assign valid_o = valid_q;
  assign pick_o  = pick_q;

endmodule

[rtl/rvr_decide.sv]
// Decision stage: applies replacement order and holds the output word.
module rvr_decide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  rvr_pkg::pick_t     pick_i,
  input  rvr_pkg::repl_cfg_t cfg_i,
  output logic               valid_o,
  output rvr_pkg::value_t    result_o,
  output rvr_pkg::rule_t     rule_o,
  output logic               empty_o
);
  import rvr_pkg::*;

  logic   nd_on;
  logic   oth_on;
  value_t result_d;
  rule_t  rule_d;
  logic   valid_q;
  value_t result_q;
  rule_t  rule_q;
  logic   empty_q;

  assign nd_on  = cfg_i.special[SPECIAL_NODATA_BIT];
  assign oth_on = cfg_i.special[SPECIAL_OTHER_BIT];

  always_comb begin
    priority if (pick_i.table_mode && pick_i.empty) begin
      result_d = pick_i.pixel;
      rule_d   = RULE_PASS;
    end else if (pick_i.table_mode && pick_i.found) begin
      result_d = pick_i.code;
      rule_d   = RULE_MATCH;
    end else if (nd_on && pick_i.nd_eq) begin
      result_d = cfg_i.nodata_new;
      rule_d   = RULE_NODATA;
    end else if (!pick_i.table_mode && pick_i.meth_hit) begin
      result_d = cfg_i.new_value;
      rule_d   = RULE_MATCH;
    end else if (oth_on && !pick_i.nd_eq) begin
      result_d = cfg_i.other_new;
      rule_d   = RULE_OTHER;
    end else begin
      result_d = pick_i.pixel;
      rule_d   = RULE_PASS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      result_q <= result_d;
      rule_q   <= rule_d;
      empty_q  <= pick_i.table_mode && pick_i.empty;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign rule_o   = rule_q;
  assign empty_o  = empty_q;

endmodule
